### sv/vtd_pkg.sv
// Shared types, register indexes and default sizes for the video time displacement block.
`default_nettype none

package vtd_pkg;

   // Default sizes handed to the top level parameters.
   localparam int HIST_DEPTH_DEF      = 16;
   localparam int FRAME_MAX_BYTES_DEF = 65536;
   localparam int QUEUE_DEPTH         = 4;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIST_LEN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES = 2'd2;

   // Register widths and reset values.
   localparam int HIST_LEN_W    = 5;
   localparam int FRAME_BYTES_W = 17;
   localparam logic                     MODE_RST        = 1'b0;
   localparam logic [HIST_LEN_W-1:0]    HIST_LEN_RST    = 5'd16;
   localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RST = 17'd65536;

   // Width of the brightness product (255 - byte) * (hist_len - 1).
   localparam int PROD_W = 13;

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic [7:0] map_delay;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } rsp_type;

   // Where the result byte of one item comes from.
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_SELF,
      SRC_RING
   } src_type;

   // Control part of one queued command.
   typedef struct packed {
      src_type    src;
      logic       last;
      logic [7:0] pix;
   } cmd_ctl_type;

endpackage

`default_nettype wire

### sv/vtd_front.sv
// Front end: configuration registers, frame tracking and classification of each byte.
`default_nettype none

module vtd_front
   import vtd_pkg::*;
#(
   parameter int HIST_DEPTH      = HIST_DEPTH_DEF,
   parameter int FRAME_MAX_BYTES = FRAME_MAX_BYTES_DEF,
   parameter int ADDR_W          = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   input  wire logic                  q_full,
   output logic                       q_push,
   output cmd_ctl_type                q_ctl,
   output logic [ADDR_W-1:0]          q_wr_addr,
   output logic [ADDR_W-1:0]          q_rd_addr
);

   localparam int POS_W  = $clog2(FRAME_MAX_BYTES);
   localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int SW1    = SLOT_W + 1;
   localparam int FH_W   = $clog2(HIST_DEPTH + 1);
   localparam int HC_W   = (FH_W > HIST_LEN_W) ? FH_W : HIST_LEN_W;
   localparam int DCMP_W = (FH_W > 8) ? FH_W : 8;
   localparam int CMP_W  = (POS_W + 1 > FRAME_BYTES_W) ? POS_W + 1 : FRAME_BYTES_W;

   // Configuration registers.
   logic                     mode_ff, mode_in;
   logic [HIST_LEN_W-1:0]    hist_len_ff, hist_len_in;
   logic [FRAME_BYTES_W-1:0] frame_bytes_ff, frame_bytes_in;

   // Frame tracking state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [FH_W-1:0]   held_ff, held_in;

   // Classification stage.
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_pix_ff, s1_pix_in;
   logic [PROD_W-1:0] s1_num_ff, s1_num_in;
   logic              s1_mode_ff, s1_mode_in;
   logic [POS_W-1:0]  s1_pos_ff, s1_pos_in;
   logic [SLOT_W-1:0] s1_newest_ff, s1_newest_in;
   logic [FH_W-1:0]   s1_held_ff, s1_held_in;
   logic              s1_last_ff, s1_last_in;

   logic                  accept;
   logic [HIST_LEN_W-1:0] hl_eff;
   logic [HIST_LEN_W-1:0] hl_m1;
   logic [CMP_W-1:0]      fb_ext;
   logic [CMP_W-1:0]      fb_eff;
   logic [CMP_W-1:0]      last_pos;
   logic                  frame_start;
   logic                  cur_last;
   logic [SLOT_W-1:0]     newest_now;
   logic [FH_W-1:0]       held_now;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W:0]       quot_sum;
   logic [7:0]            delay;
   logic [DCMP_W-1:0]     delay_ext;
   logic                  in_range;
   logic [SW1-1:0]        d_ext;
   logic [SW1-1:0]        n_ext;
   logic [SW1-1:0]        slot_diff;
   logic [SLOT_W-1:0]     rd_slot;

   // Configuration writes; indexes beyond the register list are ignored.
   always_comb begin
      mode_in        = mode_ff;
      hist_len_in    = hist_len_ff;
      frame_bytes_in = frame_bytes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        mode_in        = csr_wdata[0];
            CSR_HIST_LEN:    hist_len_in    = csr_wdata[HIST_LEN_W-1:0];
            CSR_FRAME_BYTES: frame_bytes_in = csr_wdata[FRAME_BYTES_W-1:0];
            default:         mode_in        = mode_ff;
         endcase
      end
   end

   // Effective history length: zero acts as one, clipped to the ring depth.
   always_comb begin
      if (hist_len_ff == '0) begin
         hl_eff = HIST_LEN_W'(1);
      end else if (HC_W'(hist_len_ff) > HC_W'(HIST_DEPTH)) begin
         hl_eff = HIST_LEN_W'(HIST_DEPTH);
      end else begin
         hl_eff = hist_len_ff;
      end
      hl_m1 = hl_eff - HIST_LEN_W'(1);
   end

   // Effective frame size and the position of the last byte.
   always_comb begin
      fb_ext = CMP_W'(frame_bytes_ff);
      if (fb_ext == '0) begin
         fb_eff = CMP_W'(1);
      end else if (fb_ext > CMP_W'(FRAME_MAX_BYTES)) begin
         fb_eff = CMP_W'(FRAME_MAX_BYTES);
      end else begin
         fb_eff = fb_ext;
      end
      last_pos = fb_eff - CMP_W'(1);
   end

   // Frame bookkeeping for the byte offered at the input.
   always_comb begin
      accept      = req_valid && !req_stall;
      frame_start = (pos_ff == '0);
      cur_last    = (CMP_W'(pos_ff) >= last_pos);
      newest_now  = newest_ff;
      held_now    = held_ff;
      if (frame_start && held_ff != '0) begin
         newest_now = (newest_ff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : newest_ff + SLOT_W'(1);
      end
      if (frame_start && held_ff != FH_W'(HIST_DEPTH)) begin
         held_now = held_ff + FH_W'(1);
      end
      pos_in    = pos_ff;
      newest_in = newest_ff;
      held_in   = held_ff;
      if (accept) begin
         pos_in    = cur_last ? '0 : pos_ff + POS_W'(1);
         newest_in = newest_now;
         held_in   = held_now;
      end
   end

   // The brightness product is formed at accept time.
   assign prod = {5'b0, ~req_data.pixel_byte} * {{(PROD_W - HIST_LEN_W){1'b0}}, hl_m1};

   // Stage register loads on accept and drains into the queue.
   always_comb begin
      req_stall    = s1_valid_ff && q_full;
      q_push       = s1_valid_ff && !q_full;
      s1_valid_in  = s1_valid_ff;
      s1_pix_in    = s1_pix_ff;
      s1_num_in    = s1_num_ff;
      s1_mode_in   = s1_mode_ff;
      s1_pos_in    = s1_pos_ff;
      s1_newest_in = s1_newest_ff;
      s1_held_in   = s1_held_ff;
      s1_last_in   = s1_last_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_pix_in    = req_data.pixel_byte;
         s1_num_in    = mode_ff ? prod : PROD_W'(req_data.map_delay);
         s1_mode_in   = mode_ff;
         s1_pos_in    = pos_ff;
         s1_newest_in = newest_now;
         s1_held_in   = held_now;
         s1_last_in   = cur_last;
      end else if (q_push) begin
         s1_valid_in  = 1'b0;
      end
   end

   // Delay in frames, classification and ring addresses.
   always_comb begin
      // Divide by 255 as (x + (x >> 8) + 1) >> 8, exact over the product range.
      quot_sum  = (PROD_W + 1)'(s1_num_ff) + (PROD_W + 1)'(s1_num_ff >> 8) + (PROD_W + 1)'(1);
      delay     = s1_mode_ff ? 8'(quot_sum >> 8) : s1_num_ff[7:0];
      delay_ext = DCMP_W'(delay);
      in_range  = (delay_ext < DCMP_W'(hl_eff)) && (delay_ext < DCMP_W'(s1_held_ff));
      d_ext     = SW1'(delay);
      n_ext     = {1'b0, s1_newest_ff};
      if (n_ext >= d_ext) begin
         slot_diff = n_ext - d_ext;
      end else begin
         slot_diff = n_ext + SW1'(HIST_DEPTH) - d_ext;
      end
      rd_slot = SLOT_W'(slot_diff);

      q_ctl.pix  = s1_pix_ff;
      q_ctl.last = s1_last_ff;
      if (!in_range) begin
         q_ctl.src = SRC_ZERO;
      end else if (delay == '0) begin
         q_ctl.src = SRC_SELF;
      end else begin
         q_ctl.src = SRC_RING;
      end
      q_wr_addr = ADDR_W'({s1_newest_ff, s1_pos_ff});
      q_rd_addr = ADDR_W'({rd_slot, s1_pos_ff});
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RST;
         hist_len_ff    <= HIST_LEN_RST;
         frame_bytes_ff <= FRAME_BYTES_RST;
         pos_ff         <= '0;
         newest_ff      <= '0;
         held_ff        <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         hist_len_ff    <= hist_len_in;
         frame_bytes_ff <= frame_bytes_in;
         pos_ff         <= pos_in;
         newest_ff      <= newest_in;
         held_ff        <= held_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // Payload registers of the classification stage.
   always_ff @(posedge clock) begin
      s1_pix_ff    <= s1_pix_in;
      s1_num_ff    <= s1_num_in;
      s1_mode_ff   <= s1_mode_in;
      s1_pos_ff    <= s1_pos_in;
      s1_newest_ff <= s1_newest_in;
      s1_held_ff   <= s1_held_in;
      s1_last_ff   <= s1_last_in;
   end

`ifndef SYNTHESIS
   // A classified byte always belongs to a frame that has been counted.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_held_ff != '0 && s1_held_ff <= FH_W'(HIST_DEPTH)))
      else $error("classified byte without a held frame");

   // A wrapped position comes only from the last byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff != '0) |=> (pos_ff == '0) == $past(cur_last))
      else $error("frame position did not follow the last byte flag");
`endif

endmodule

`default_nettype wire

### sv/vtd_queue.sv
// Short command queue that decouples the front end from the ring memory side.
`default_nettype none

module vtd_queue
   import vtd_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      head_data,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      head_data = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // The fill count never passes the depth and a full queue takes no push.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(DEPTH)) && !(push && full))
      else $error("command queue overflow");

   // An empty queue is never popped.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue underflow");
`endif

endmodule

`default_nettype wire

### sv/vtd_back.sv
// Back end: frame ring memory write and read, result selection and output register.
`default_nettype none

module vtd_back
   import vtd_pkg::*;
#(
   parameter int HIST_DEPTH      = HIST_DEPTH_DEF,
   parameter int FRAME_MAX_BYTES = FRAME_MAX_BYTES_DEF,
   parameter int ADDR_W          = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  wire cmd_ctl_type       q_ctl,
   input  wire logic [ADDR_W-1:0] q_wr_addr,
   input  wire logic [ADDR_W-1:0] q_rd_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data
);

   localparam int POS_W     = $clog2(FRAME_MAX_BYTES);
   localparam int MEM_DEPTH = HIST_DEPTH * (2 ** POS_W);

   // Ring of recent frames; never cleared, so a read may hit an entry never written.
   logic [7:0] ring_mem [MEM_DEPTH];

   logic       b1_valid_ff, b1_valid_in;
   src_type    b1_src_ff, b1_src_in;
   logic [7:0] b1_pix_ff, b1_pix_in;
   logic       b1_last_ff, b1_last_in;
   logic [7:0] rd_data_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic       out_load;
   logic [7:0] sel_byte;

   // Handshake between queue, memory stage and output register.
   always_comb begin
      out_load = b1_valid_ff && (!out_valid_ff || !rsp_stall);
      q_pop    = !q_empty && (!b1_valid_ff || out_load);

      b1_valid_in = b1_valid_ff;
      b1_src_in   = b1_src_ff;
      b1_pix_in   = b1_pix_ff;
      b1_last_in  = b1_last_ff;
      if (q_pop) begin
         b1_valid_in = 1'b1;
         b1_src_in   = q_ctl.src;
         b1_pix_in   = q_ctl.pix;
         b1_last_in  = q_ctl.last;
      end else if (out_load) begin
         b1_valid_in = 1'b0;
      end
   end

   // Result byte selection.
   always_comb begin
      unique case (b1_src_ff)
         SRC_SELF: sel_byte = b1_pix_ff;
         SRC_RING: sel_byte = rd_data_ff;
         default:  sel_byte = '0;
      endcase
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_load) begin
         out_valid_in          = 1'b1;
         out_data_in.out_byte   = sel_byte;
         out_data_in.frame_last = b1_last_ff;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // One write and one registered read per popped command.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ring_mem[q_wr_addr] <= q_ctl.pix;
         rd_data_ff          <= ring_mem[q_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_src_ff   <= b1_src_in;
      b1_pix_ff   <= b1_pix_in;
      b1_last_ff  <= b1_last_in;
      out_data_ff <= out_data_in;
   end

`ifndef SYNTHESIS
   // A ring read never targets the entry written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_ctl.src == SRC_RING) |-> (q_rd_addr != q_wr_addr))
      else $error("ring read collides with ring write");
`endif

endmodule

`default_nettype wire

### sv/video_time_displacement.sv
// Inputs pass the classification stage, command queue, memory stage and output register.
// Throughput: one byte per cycle if unstalled, set by the single ring write and read port.
// The ring memory holds HIST_DEPTH slots of 2**clog2(FRAME_MAX_BYTES) bytes each.
// Reset clears frame position, newest slot, frame count and all valid flags at once.
// Registers return to mode 0, hist_len 16 and frame_bytes 65536; the ring is not cleared.
`default_nettype none

module video_time_displacement
   import vtd_pkg::*;
#(
   parameter int HIST_DEPTH      = HIST_DEPTH_DEF,
   parameter int FRAME_MAX_BYTES = FRAME_MAX_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data
);

   localparam int POS_W     = $clog2(FRAME_MAX_BYTES);
   localparam int MEM_DEPTH = HIST_DEPTH * (2 ** POS_W);
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CTL_W     = $bits(cmd_ctl_type);
   localparam int Q_W       = 2 * ADDR_W + CTL_W;

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   cmd_ctl_type       push_ctl;
   logic [ADDR_W-1:0] push_wr_addr;
   logic [ADDR_W-1:0] push_rd_addr;
   logic [Q_W-1:0]    push_word;
   logic [Q_W-1:0]    head_word;
   cmd_ctl_type       head_ctl;
   logic [ADDR_W-1:0] head_wr_addr;
   logic [ADDR_W-1:0] head_rd_addr;

   // Commands travel through the queue as one packed word.
   assign push_word = {push_rd_addr, push_wr_addr, push_ctl};
   assign {head_rd_addr, head_wr_addr, head_ctl} = head_word;

   vtd_front #(
      .HIST_DEPTH      (HIST_DEPTH),
      .FRAME_MAX_BYTES (FRAME_MAX_BYTES),
      .ADDR_W          (ADDR_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_ctl     (push_ctl),
      .q_wr_addr (push_wr_addr),
      .q_rd_addr (push_rd_addr)
   );

   vtd_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (head_word),
      .empty     (q_empty)
   );

   vtd_back #(
      .HIST_DEPTH      (HIST_DEPTH),
      .FRAME_MAX_BYTES (FRAME_MAX_BYTES),
      .ADDR_W          (ADDR_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_ctl     (head_ctl),
      .q_wr_addr (head_wr_addr),
      .q_rd_addr (head_rd_addr),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### dv/tb_video_time_displacement.sv
// Self-checking testbench for the video time displacement block.
`default_nettype none

module tb_video_time_displacement;
   import vtd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_N      = HIST_DEPTH_DEF;
   localparam int FRAME_N     = FRAME_MAX_BYTES_DEF;
   localparam int RANDOM_ITEMS = 1350;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int PRINT_MAX   = 40;

   // One row of the directed stimulus table.
   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [7:0]            pix;
      logic [7:0]            map;
      bit                    typed;
      logic [7:0]            exp_byte;
      bit                    exp_last;
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;

   // Predictor state: history ring with a written flag in bit 8 of each entry.
   bit [8:0]             frame_store [HIST_N][FRAME_N];
   int unsigned          pos_m = 0;
   int unsigned          slot_m = 0;
   int unsigned          held_m = 0;
   bit                   mode_m = MODE_RST;
   logic [4:0]           hist_m = HIST_LEN_RST;
   logic [16:0]          fbytes_m = FRAME_BYTES_RST;

   rsp_type              pending_rsp [$];
   step_type             plan [$];
   int                   err_count = 0;
   int                   rsp_seen = 0;
   int                   cycles = 0;
   int                   burst_left = 0;

   video_time_displacement u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < PRINT_MAX) begin
         $display("mismatch at result %0d: %s got %0h want %0h", rsp_seen, what, got, want);
      end
      err_count++;
   endtask

   // History length in use after clamping to 1..HIST_N.
   function automatic int unsigned eff_hist_len();
      if (hist_m == 0) return 1;
      if (hist_m > HIST_N) return HIST_N;
      return hist_m;
   endfunction

   // Advance the predictor by one byte; flags a read of a never-written entry.
   function automatic rsp_type displace_byte(input req_type t, output bit blank_hit);
      int unsigned hl;
      int unsigned fb;
      int unsigned dly;
      int unsigned src_slot;
      rsp_type     r;
      hl = eff_hist_len();
      fb = (fbytes_m == 0) ? 1 : (fbytes_m > FRAME_N) ? FRAME_N : fbytes_m;
      blank_hit = 1'b0;
      if (pos_m >= FRAME_N) pos_m = 0;
      // A new frame takes the next ring slot.
      if (pos_m == 0) begin
         if (held_m != 0) slot_m = (slot_m + 1) % HIST_N;
         if (held_m < HIST_N) held_m++;
      end
      frame_store[slot_m][pos_m] = {1'b1, t.pixel_byte};
      if (mode_m) begin
         dly = ((255 - int'(t.pixel_byte)) * (hl - 1)) / 255;
      end else begin
         dly = t.map_delay;
      end
      r.out_byte = 8'h00;
      if (dly < hl && dly < held_m) begin
         src_slot = (slot_m + HIST_N - dly) % HIST_N;
         blank_hit = !frame_store[src_slot][pos_m][8];
         r.out_byte = frame_store[src_slot][pos_m][7:0];
      end
      r.frame_last = (pos_m >= fb - 1);
      pos_m = r.frame_last ? 0 : pos_m + 1;
      return r;
   endfunction

   // Register write, only once every pending result has come back.
   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODE:        mode_m = data[0];
         CSR_HIST_LEN:    hist_m = data[4:0];
         CSR_FRAME_BYTES: fbytes_m = data[16:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one byte in bursts with random gaps; predict it and wait for acceptance.
   task automatic offer_pixel(input req_type t, input bit typed, input rsp_type typed_rsp);
      int unsigned gap;
      int unsigned save_pos;
      int unsigned save_slot;
      int unsigned save_held;
      bit          blank_hit;
      rsp_type     want;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      save_pos  = pos_m;
      save_slot = slot_m;
      save_held = held_m;
      want = displace_byte(t, blank_hit);
      // Steer away from history entries never written since frame_bytes grew.
      if (blank_hit) begin
         pos_m  = save_pos;
         slot_m = save_slot;
         held_m = save_held;
         if (mode_m) t.pixel_byte = 8'hFF;
         else t.map_delay = 8'h00;
         want = displace_byte(t, blank_hit);
      end
      pending_rsp.push_back(typed ? typed_rsp : want);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic step_type pix_row(input logic [7:0] p, input logic [7:0] m,
                                        input bit typed = 0, input logic [7:0] eb = 0,
                                        input bit el = 0);
      step_type s;
      s = '{0, CSR_MODE, '0, p, m, typed, eb, el};
      return s;
   endfunction

   function automatic step_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] data);
      step_type s;
      s = '{1, idx, data, 8'h00, 8'h00, 0, 8'h00, 0};
      return s;
   endfunction

   // Result checker: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result", rsp_data, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
            if (rsp_data.frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_data.frame_last, want.frame_last);
         end
      end
   end

   // Receiver stall patterns, with one long hold-off while the sender is busy.
   initial begin
      int unsigned run;
      int unsigned kind;
      bit          held_once;
      held_once = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_once && rsp_seen >= 300 && req_valid) begin
            held_once = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         kind = $urandom_range(0, 3);
         run  = $urandom_range(5, 60);
         repeat (run) begin
            case (kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= (cycles % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 99) < 75);
            endcase
            @(posedge clock);
         end
      end
   end

   // Main sequence: directed table, then random phases of settings and bytes.
   initial begin
      int unsigned sent;
      int unsigned n_items;
      int unsigned r;
      int unsigned hl;
      logic [4:0]  hist_val;
      logic [16:0] fb_val;
      req_type     t;
      bit          first_phase;

      // Reset defaults first, then mid-frame shrink, clamped registers and both modes.
      plan.push_back(pix_row(8'hA5, 8'h00, 1, 8'hA5, 0));
      plan.push_back(pix_row(8'h00, 8'h01, 1, 8'h00, 0));
      plan.push_back(pix_row(8'hFF, 8'hFF, 1, 8'h00, 0));
      plan.push_back(pix_row(8'h5A, 8'h00, 1, 8'h5A, 0));
      plan.push_back(csr_row(CSR_FRAME_BYTES, 17'd2));
      plan.push_back(pix_row(8'h11, 8'h00, 1, 8'h11, 1));
      plan.push_back(pix_row(8'h22, 8'h01));
      plan.push_back(pix_row(8'h33, 8'h01));
      plan.push_back(csr_row(CSR_MODE, 17'h1FFFF));
      plan.push_back(csr_row(CSR_HIST_LEN, 17'h1FFE0));
      plan.push_back(pix_row(8'h00, 8'h9C, 1, 8'h00, 0));
      plan.push_back(pix_row(8'hFF, 8'h00, 1, 8'hFF, 1));
      plan.push_back(csr_row(CSR_HIST_LEN, 17'h0001F));
      plan.push_back(pix_row(8'h00, 8'h00, 1, 8'h00, 0));
      plan.push_back(pix_row(8'hFF, 8'h00, 1, 8'hFF, 1));
      plan.push_back(pix_row(8'h80, 8'h3C));
      plan.push_back(pix_row(8'hC0, 8'hC3));
      plan.push_back(csr_row(CSR_MODE, 17'h1FFFE));
      plan.push_back(csr_row(CSR_HIST_LEN, 17'd2));
      plan.push_back(pix_row(8'h44, 8'h02, 1, 8'h00, 0));
      plan.push_back(pix_row(8'h55, 8'h01));
      plan.push_back(csr_row(CSR_FRAME_BYTES, 17'd0));
      plan.push_back(pix_row(8'h66, 8'h00, 1, 8'h66, 1));
      plan.push_back(pix_row(8'h77, 8'h01));
      plan.push_back(csr_row(CSR_FRAME_BYTES, 17'h1FFFF));
      plan.push_back(csr_row(CSR_HIST_LEN, 17'd16));
      plan.push_back(pix_row(8'h88, 8'h0F));
      plan.push_back(pix_row(8'h99, 8'h00));
      plan.push_back(pix_row(8'hAA, 8'h08));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            program_reg(plan[i].idx, plan[i].wdata);
         end else begin
            t.pixel_byte = plan[i].pix;
            t.map_delay  = plan[i].map;
            offer_pixel(t, plan[i].typed, '{out_byte: plan[i].exp_byte,
                                           frame_last: plan[i].exp_last});
         end
      end

      // Random phases; a phase boundary that writes a register lets the block drain completely.
      sent = 0;
      first_phase = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (first_phase || $urandom_range(0, 99) < 60)
            program_reg(CSR_MODE, CSR_DATA_W'($urandom()));
         if (first_phase || $urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 99);
            if (r < 20) hist_val = 5'd1;
            else if (r < 40) hist_val = 5'd16;
            else if (r < 50) hist_val = 5'd0;
            else if (r < 60) hist_val = 5'($urandom_range(17, 31));
            else hist_val = 5'($urandom_range(2, 15));
            program_reg(CSR_HIST_LEN, (CSR_DATA_W'($urandom()) & 17'h1FFE0) | hist_val);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 99);
            if (r < 8) fb_val = 17'd0;
            else if (r < 14) fb_val = 17'd1;
            else if (r < 17) fb_val = 17'd65536;
            else if (r < 19) fb_val = 17'h1FFFF;
            else if (r < 24) fb_val = 17'($urandom());
            else fb_val = 17'($urandom_range(2, 48));
            program_reg(CSR_FRAME_BYTES, fb_val);
         end
         first_phase = 1'b0;
         n_items = $urandom_range(10, 100);
         repeat (n_items) begin
            hl = eff_hist_len();
            t.pixel_byte = 8'($urandom());
            if ($urandom_range(0, 99) < 70) t.map_delay = 8'($urandom_range(0, hl));
            else t.map_delay = 8'($urandom());
            offer_pixel(t, 1'b0, '0);
            sent++;
         end
      end

      // Drain, then keep watching for any stray result.
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

### video_time_displacement.f
sv/vtd_pkg.sv
sv/vtd_front.sv
sv/vtd_queue.sv
sv/vtd_back.sv
sv/video_time_displacement.sv
dv/tb_video_time_displacement.sv
